@@ rtl/core/assert_macros.svh @@
// Assertion macros for the row transition band detector RTL, included by its result buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/rbd_pkg.sv @@
// Types and constants of the row transition band detector.
package rbd_pkg;

  localparam int unsigned RowW = 10;
  localparam int unsigned CntW = 10;
  localparam int unsigned QualW = 11;

  typedef logic [RowW-1:0] row_idx_t;
  typedef logic [CntW-1:0] jump_cnt_t;
  typedef logic [QualW-1:0] qual_cnt_t;

  localparam jump_cnt_t RstBandJump = 10'd7;
  localparam row_idx_t RstMinHeight = 10'd8;
  localparam jump_cnt_t RstVerifyJump = 10'd15;
  localparam qual_cnt_t RstMinQual = 11'd15;
  localparam qual_cnt_t QualMax = '1;

  typedef enum logic [1:0] {
    CfgBandJump = 2'd0,
    CfgMinHeight = 2'd1,
    CfgVerifyJump = 2'd2,
    CfgMinQual = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cfg_reg_e index;
    logic [QualW-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    jump_cnt_t band_jump_threshold;
    row_idx_t min_band_height;
    jump_cnt_t verify_jump_threshold;
    qual_cnt_t min_qualifying_rows;
  } cfg_set_t;

  typedef struct packed {
    logic pixel_bit;
    logic row_end;
    logic frame_end;
  } pix_t;

  typedef struct packed {
    row_idx_t row_number;
    jump_cnt_t row_jumps;
    logic band_closed;
    row_idx_t band_first_row;
    row_idx_t band_last_row;
    qual_cnt_t qualifying_rows;
    logic frame_done;
    logic plate_like;
  } res_t;

endpackage

@@ rtl/core/rbd_stream_if.sv @@
// Valid/ready channel carrying one beat of a typed payload.
interface rbd_stream_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/row_transition_band_detector.sv @@
// Top level of the row transition band detector.
// Takes one binarized pixel beat per clock while pix_i is ready and returns one
// result beat per ended row: the row's last pixel is held in the input register,
// then the count, band and verdict logic writes the two-entry result buffer.
// pix_i stalls only while the skid entry of the buffer is full and the registered
// pixel ends a row. Configuration writes are always ready and apply to the next
// row evaluated.
module row_transition_band_detector #(
  parameter int unsigned MAX_ROW_WIDTH = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rbd_stream_if.sink          pix_i,
  rbd_stream_if.source        res_o,
  rbd_stream_if.sink          cfg_i
);
  import rbd_pkg::*;

  localparam int unsigned JumpLimInt = (MAX_ROW_WIDTH - 1 > 1023) ? 1023 : MAX_ROW_WIDTH - 1;
  localparam int unsigned LastRowInt = (MAX_ROWS - 1 > 1023) ? 1023 : MAX_ROWS - 1;
  localparam logic [9:0] JumpLim = 10'(JumpLimInt);
  localparam logic [9:0] LastRow = 10'(LastRowInt);

  cfg_set_t cfg_q, cfg_d;
  cfg_wr_t  cfg_wr;
  logic     in_vld_q, in_vld_d;
  pix_t     in_q;
  logic     adv;
  logic     has_res;
  logic     space;
  res_t     res;
  res_t     res_data;
  logic     res_valid;

  assign cfg_wr = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_wr.index)
        CfgBandJump:   cfg_d.band_jump_threshold = cfg_wr.value[9:0];
        CfgMinHeight:  cfg_d.min_band_height = cfg_wr.value[9:0];
        CfgVerifyJump: cfg_d.verify_jump_threshold = cfg_wr.value[9:0];
        CfgMinQual:    cfg_d.min_qualifying_rows = cfg_wr.value;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_jump_threshold <= RstBandJump;
      cfg_q.min_band_height <= RstMinHeight;
      cfg_q.verify_jump_threshold <= RstVerifyJump;
      cfg_q.min_qualifying_rows <= RstMinQual;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // advance the registered beat unless its result has nowhere to go
  assign adv = in_vld_q && (!has_res || space);
  assign pix_i.ready = !in_vld_q || adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (pix_i.ready) begin
      in_vld_d = pix_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.ready && pix_i.valid) begin
      in_q <= pix_i.data;
    end
  end

  rbd_row_core #(
    .JumpLim(JumpLim),
    .LastRow(LastRow)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .pix_i    (in_q),
    .cfg_i    (cfg_q),
    .has_res_o(has_res),
    .res_o    (res)
  );

  rbd_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv && has_res),
    .data_i (res),
    .space_o(space),
    .valid_o(res_valid),
    .ready_i(res_o.ready),
    .data_o (res_data)
  );

  assign res_o.valid = res_valid;
  assign res_o.data = res_data;

endmodule

@@ rtl/core/rbd_row_core.sv @@
// Per-row transition counting, band tracking and frame verdict.
module rbd_row_core #(
  parameter logic [9:0] JumpLim = 10'd1023,
  parameter logic [9:0] LastRow = 10'd1023
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  rbd_pkg::pix_t     pix_i,
  input  rbd_pkg::cfg_set_t cfg_i,
  output logic              has_res_o,
  output rbd_pkg::res_t     res_o
);
  import rbd_pkg::*;

  logic      prev_q, prev_d;
  logic      started_q, started_d;
  jump_cnt_t jump_q, jump_d;
  row_idx_t  row_q, row_d;
  logic      band_open_q, band_open_d;
  row_idx_t  band_start_q, band_start_d;
  qual_cnt_t qual_q, qual_d;

  logic      inc;
  jump_cnt_t jumps;
  logic      row_end;
  logic      band_hit;
  logic      closed;
  row_idx_t  span;
  qual_cnt_t qual_new;

  always_comb begin
    inc = started_q && (pix_i.pixel_bit != prev_q) && (jump_q < JumpLim);
    jumps = jump_q + jump_cnt_t'(inc);
    row_end = pix_i.row_end || pix_i.frame_end;
    band_hit = jumps >= cfg_i.band_jump_threshold;
    span = row_q - band_start_q;
    closed = !band_hit && band_open_q && (span >= cfg_i.min_band_height);
    qual_new = ((jumps >= cfg_i.verify_jump_threshold) && (qual_q != QualMax)) ?
               qual_q + qual_cnt_t'(1) : qual_q;

    has_res_o = row_end;
    res_o.row_number = row_q;
    res_o.row_jumps = jumps;
    res_o.band_closed = closed;
    res_o.band_first_row = closed ? band_start_q : '0;
    res_o.band_last_row = closed ? row_q - row_idx_t'(1) : '0;
    res_o.qualifying_rows = qual_new;
    res_o.frame_done = pix_i.frame_end;
    res_o.plate_like = pix_i.frame_end && (qual_new > cfg_i.min_qualifying_rows);

    prev_d = prev_q;
    started_d = started_q;
    jump_d = jump_q;
    row_d = row_q;
    band_open_d = band_open_q;
    band_start_d = band_start_q;
    qual_d = qual_q;
    if (adv_i) begin
      if (!row_end) begin
        prev_d = pix_i.pixel_bit;
        started_d = 1'b1;
        jump_d = jumps;
      end else if (pix_i.frame_end) begin
        prev_d = 1'b0;
        started_d = 1'b0;
        jump_d = '0;
        row_d = '0;
        band_open_d = 1'b0;
        band_start_d = '0;
        qual_d = '0;
      end else begin
        prev_d = 1'b0;
        started_d = 1'b0;
        jump_d = '0;
        row_d = (row_q >= LastRow) ? '0 : row_q + row_idx_t'(1);
        qual_d = qual_new;
        if (band_hit && !band_open_q) begin
          band_open_d = 1'b1;
          band_start_d = row_q;
        end else if (closed) begin
          band_open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      started_q <= 1'b0;
      jump_q <= '0;
      row_q <= '0;
      band_open_q <= 1'b0;
      band_start_q <= '0;
      qual_q <= '0;
    end else begin
      prev_q <= prev_d;
      started_q <= started_d;
      jump_q <= jump_d;
      row_q <= row_d;
      band_open_q <= band_open_d;
      band_start_q <= band_start_d;
      qual_q <= qual_d;
    end
  end

endmodule

@@ rtl/core/rbd_out_buf.sv @@
// Two-entry result buffer: output register plus skid register.
module rbd_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rbd_pkg::res_t data_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output rbd_pkg::res_t data_o
);
  import rbd_pkg::*;

`include "assert_macros.svh"

  logic main_vld_q, main_vld_d;
  logic skid_vld_q, skid_vld_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = main_vld_q && ready_i;
  assign space_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o = main_q;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d = main_q;
    skid_d = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        main_d = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_d = data_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      main_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  `RBD_ASSERT_NOW(a_skid_behind_main, skid_vld_q, main_vld_q)
  `RBD_ASSERT_NOW(a_no_push_when_full, push_i, !skid_vld_q)
  `RBD_ASSERT_NEXT(a_skid_refills_main, skid_vld_q && pop, main_vld_q && !skid_vld_q)
  `RBD_ASSERT_NEXT(a_push_lands, push_i, main_vld_q)

endmodule

@@ sim/tb_row_transition_band_detector.sv @@
// Self-checking testbench for row_transition_band_detector: pixel streams against a row predictor.
module tb_row_transition_band_detector;
  import rbd_pkg::*;

  localparam int unsigned RowWidthMax = 1024;
  localparam int unsigned RowsMax = 1024;
  localparam jump_cnt_t JumpCap = (RowWidthMax - 1 > 1023) ? 10'd1023 :
                                  jump_cnt_t'(RowWidthMax - 1);
  localparam row_idx_t LastRow = (RowsMax - 1 > 1023) ? 10'd1023 : row_idx_t'(RowsMax - 1);
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned RandomPixels = 1200;

  logic clk;
  logic rst_n;

  rbd_stream_if #(.payload_t(pix_t)) pix_if ();
  rbd_stream_if #(.payload_t(res_t)) res_if ();
  rbd_stream_if #(.payload_t(cfg_wr_t)) cfg_if ();

  row_transition_band_detector #(
    .MAX_ROW_WIDTH(RowWidthMax),
    .MAX_ROWS(RowsMax)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .pix_i(pix_if),
    .res_o(res_if),
    .cfg_i(cfg_if)
  );

  jump_cnt_t cfg_band;
  row_idx_t cfg_height;
  jump_cnt_t cfg_verify;
  qual_cnt_t cfg_qual;

  logic prev_px;
  logic row_live;
  jump_cnt_t jumps_acc;
  row_idx_t row_idx;
  logic band_active;
  row_idx_t band_top;
  qual_cnt_t qual_cnt;

  res_t expected_rows[$];
  int unsigned mismatches;
  int unsigned pixels_taken;
  int unsigned cycle_count;
  int unsigned result_hold;
  bit pix_steady;
  bit res_steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_frame_state();
    prev_px = 1'b0;
    row_live = 1'b0;
    jumps_acc = '0;
    row_idx = '0;
    band_active = 1'b0;
    band_top = '0;
    qual_cnt = '0;
  endfunction

  function automatic void track_pixel(pix_t px);
    res_t r;
    row_idx_t span;
    if (row_live && px.pixel_bit != prev_px && jumps_acc < JumpCap) jumps_acc++;
    prev_px = px.pixel_bit;
    row_live = 1'b1;
    if (!px.row_end && !px.frame_end) return;
    r = '0;
    r.row_number = row_idx;
    r.row_jumps = jumps_acc;
    if (jumps_acc >= cfg_band) begin
      if (!band_active) begin
        band_active = 1'b1;
        band_top = row_idx;
      end
    end else if (band_active) begin
      span = row_idx - band_top;
      if (span >= cfg_height) begin
        r.band_closed = 1'b1;
        r.band_first_row = band_top;
        r.band_last_row = row_idx - row_idx_t'(1);
        band_active = 1'b0;
      end
    end
    if (jumps_acc >= cfg_verify && qual_cnt != QualMax) qual_cnt++;
    r.qualifying_rows = qual_cnt;
    r.frame_done = px.frame_end;
    r.plate_like = px.frame_end && (qual_cnt > cfg_qual);
    expected_rows.insert(expected_rows.size(), r);
    if (px.frame_end) begin
      clear_frame_state();
    end else begin
      jumps_acc = '0;
      row_live = 1'b0;
      prev_px = 1'b0;
      row_idx = (row_idx >= LastRow) ? '0 : row_idx + row_idx_t'(1);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random stalls plus an externally requested hold-off.
  initial begin
    int unsigned res_pause;
    res_pause = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (result_hold > 0) begin
        res_if.ready <= 1'b0;
        result_hold--;
      end else if (res_pause > 0 && !res_steady) begin
        res_if.ready <= 1'b0;
        res_pause--;
      end else begin
        res_if.ready <= 1'b1;
        res_pause = res_steady ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (expected_rows.size() == 0) begin
        $error("unexpected result beat: row_number %0d", got.row_number);
        mismatches++;
      end else begin
        want = expected_rows.pop_front();
        check_field("row_number", 32'(want.row_number), 32'(got.row_number));
        check_field("row_jumps", 32'(want.row_jumps), 32'(got.row_jumps));
        check_field("band_closed", 32'(want.band_closed), 32'(got.band_closed));
        check_field("band_first_row", 32'(want.band_first_row), 32'(got.band_first_row));
        check_field("band_last_row", 32'(want.band_last_row), 32'(got.band_last_row));
        check_field("qualifying_rows", 32'(want.qualifying_rows),
                    32'(got.qualifying_rows));
        check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
        check_field("plate_like", 32'(want.plate_like), 32'(got.plate_like));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_row_transition_band_detector NOT OK");
    $finish;
  end

  task automatic send_pixel(logic pb, logic re, logic fe);
    pix_t p;
    int unsigned gap;
    p.pixel_bit = pb;
    p.row_end = re;
    p.frame_end = fe;
    gap = pix_steady ? 0 : pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.data <= p;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    track_pixel(p);
    pixels_taken++;
    @(negedge clk);
  endtask

  task automatic send_row(int unsigned width, int unsigned flip_pct, bit frame_last,
                          bit skip_row_end);
    logic pb;
    pb = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < width; i++) begin
      if (i > 0 && $urandom_range(0, 99) < flip_pct) pb = ~pb;
      send_pixel(pb, (i == width - 1) && !(frame_last && skip_row_end),
                 (i == width - 1) && frame_last);
    end
  endtask

  task automatic settle_block();
    pix_if.valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic apply_cfg(jump_cnt_t band, row_idx_t height, jump_cnt_t verify,
                           qual_cnt_t qual);
    cfg_reg_e regs[4];
    qual_cnt_t vals[4];
    regs = '{CfgBandJump, CfgMinHeight, CfgVerifyJump, CfgMinQual};
    vals = '{qual_cnt_t'(band), qual_cnt_t'(height), qual_cnt_t'(verify), qual};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data <= cfg_wr_t'{index: regs[i], value: vals[i]};
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      case (regs[i])
        CfgBandJump: cfg_band = jump_cnt_t'(vals[i]);
        CfgMinHeight: cfg_height = row_idx_t'(vals[i]);
        CfgVerifyJump: cfg_verify = jump_cnt_t'(vals[i]);
        CfgMinQual: cfg_qual = vals[i];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    for (int unsigned r = 0; r < 17; r++) send_row(17, 100, 1'b0, 1'b0);
    send_row(17, 0, 1'b0, 1'b0);
    send_row(5, 100, 1'b1, 1'b0);
    settle_block();
  endtask

  task automatic test_edge_rows();
    apply_cfg(10'd1, 10'd0, 10'd1, 11'd0);
    send_pixel(1'b1, 1'b1, 1'b0);
    send_pixel(1'b0, 1'b0, 1'b0);
    send_pixel(1'b1, 1'b1, 1'b0);
    send_pixel(1'b1, 1'b1, 1'b0);
    send_pixel(1'b1, 1'b0, 1'b0);
    send_pixel(1'b0, 1'b0, 1'b1);
    send_pixel(1'b0, 1'b1, 1'b1);
    settle_block();
  endtask

  task automatic test_jump_saturation();
    apply_cfg(10'd1023, 10'd0, 10'd1023, 11'd1024);
    send_row(1030, 100, 1'b0, 1'b0);
    send_pixel(1'b0, 1'b1, 1'b0);
    send_pixel(1'b1, 1'b0, 1'b1);
    settle_block();
  endtask

  task automatic test_tall_frames();
    apply_cfg(10'd0, 10'd1023, 10'd0, 11'd1024);
    for (int unsigned r = 0; r < 2100; r++)
      send_pixel(1'($urandom_range(0, 1)), 1'b1, r == 2099);
    settle_block();
    apply_cfg(10'd1, 10'd1023, 10'd1023, 11'd0);
    send_pixel(1'b0, 1'b0, 1'b0);
    send_pixel(1'b1, 1'b1, 1'b0);
    for (int unsigned r = 0; r < 1100; r++)
      send_pixel(1'($urandom_range(0, 1)), 1'b1, r == 1099);
    settle_block();
  endtask

  task automatic test_result_backpressure();
    apply_cfg(10'd2, 10'd1, 10'd3, 11'd4);
    pix_steady = 1'b1;
    result_hold = 200;
    for (int unsigned r = 0; r < 60; r++) send_row($urandom_range(1, 4), 70, r == 59, 1'b0);
    pix_steady = 1'b0;
    settle_block();
  endtask

  task automatic send_random_frame();
    int unsigned rows;
    int unsigned band_from;
    int unsigned band_to;
    int unsigned width;
    int unsigned flip;
    rows = $urandom_range(1, 14);
    band_from = $urandom_range(0, rows - 1);
    band_to = $urandom_range(band_from, rows - 1);
    for (int unsigned r = 0; r < rows; r++) begin
      width = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      flip = (r >= band_from && r <= band_to) ? $urandom_range(60, 100) : $urandom_range(0, 25);
      send_row(width, flip, r == rows - 1, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 30);
    repeat (n)
      send_pixel(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                 $urandom_range(0, 15) == 0);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned frames;
    start = pixels_taken;
    while (pixels_taken - start < RandomPixels) begin
      if ($urandom_range(0, 5) == 0)
        apply_cfg($urandom_range(0, 1) ? 10'd1023 : 10'd0,
                  $urandom_range(0, 1) ? 10'd1023 : 10'd0,
                  $urandom_range(0, 1) ? 10'd1023 : 10'd0,
                  $urandom_range(0, 1) ? 11'd1024 : 11'd0);
      else
        apply_cfg(jump_cnt_t'($urandom_range(0, 12)), row_idx_t'($urandom_range(0, 6)),
                  jump_cnt_t'($urandom_range(0, 16)), qual_cnt_t'($urandom_range(0, 8)));
      pix_steady = ($urandom_range(0, 3) == 0);
      res_steady = ($urandom_range(0, 3) == 0);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_random_frame();
      end
      settle_block();
    end
    pix_steady = 1'b0;
    res_steady = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    pixels_taken = 0;
    result_hold = 0;
    pix_steady = 1'b0;
    res_steady = 1'b0;
    cfg_band = RstBandJump;
    cfg_height = RstMinHeight;
    cfg_verify = RstVerifyJump;
    cfg_qual = RstMinQual;
    clear_frame_state();
    rst_n <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_edge_rows();
    test_jump_saturation();
    test_tall_frames();
    test_result_backpressure();
    test_random_frames();
    settle_block();
    if (mismatches == 0) begin
      $display("tb_row_transition_band_detector OK");
    end else begin
      $display("tb_row_transition_band_detector NOT OK");
    end
    $finish;
  end

endmodule
